// File: rtl/lfcd_pkg.sv
// Shared types and constants for the length framed command deframer.
`timescale 1ns / 1ps

package lfcd_pkg;

  // Parser modes; any other value reached through a length byte is invalid.
  localparam logic [7:0] MODE_IDLE      = 8'd0;
  localparam logic [7:0] MODE_LENGTH    = 8'd1;
  localparam logic [7:0] MODE_END_CHECK = 8'd2;
  localparam logic [7:0] MODE_COLLECT_3 = 8'd3;
  localparam logic [7:0] MODE_COLLECT_4 = 8'd4;
  localparam logic [7:0] MODE_COLLECT_8 = 8'd8;

  // Command codes carried in the first payload byte.
  localparam logic [7:0] CMD_RESET_SAMPLE = 8'h01;
  localparam logic [7:0] CMD_SAMPLE_TIMER = 8'h02;

  typedef enum logic [1:0] {
    ACT_NONE         = 2'd0,
    ACT_RESET_SAMPLE = 2'd1,
    ACT_SAMPLE_TIMER = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_START_BYTE       = 2'd0,
    REG_END_BYTE         = 2'd1,
    REG_ONE_WORD_LENGTH  = 2'd2,
    REG_TWO_WORDS_LENGTH = 2'd3
  } reg_index_t;

  localparam logic [7:0] RST_START_BYTE       = 8'd170;
  localparam logic [7:0] RST_END_BYTE         = 8'd85;
  localparam logic [7:0] RST_ONE_WORD_LENGTH  = 8'd3;
  localparam logic [7:0] RST_TWO_WORDS_LENGTH = 8'd4;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] one_word_length;
    logic [7:0] two_words_length;
  } cfg_t;

  typedef struct packed {
    logic    accepted;
    action_t action;
  } result_t;

endpackage

// File: rtl/lfcd_parser.sv
// Frame parser state machine: consumes one byte per request and forms its result.
`timescale 1ns / 1ps

module lfcd_parser import lfcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output result_t    result
);

  logic [7:0] mode, mode_next;
  logic [7:0] frame_length, frame_length_next;
  logic [3:0] payload_count, payload_count_next;
  logic [7:0] first_payload_byte, first_payload_byte_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= MODE_IDLE;
      frame_length       <= 8'd0;
      payload_count      <= 4'd0;
      first_payload_byte <= 8'd0;
    end else if (take) begin
      mode               <= mode_next;
      frame_length       <= frame_length_next;
      payload_count      <= payload_count_next;
      first_payload_byte <= first_payload_byte_next;
    end
  end

  always_comb begin
    mode_next               = mode;
    frame_length_next       = frame_length;
    payload_count_next      = payload_count;
    first_payload_byte_next = first_payload_byte;
    result.accepted         = 1'b1;
    result.action           = ACT_NONE;
    case (mode) inside
      MODE_IDLE: begin
        if (rx_byte == cfg.start_byte) mode_next = MODE_LENGTH;
      end
      MODE_LENGTH: begin
        // The length byte doubles as the next mode.
        frame_length_next  = rx_byte;
        mode_next          = rx_byte;
        payload_count_next = 4'd0;
      end
      MODE_END_CHECK: begin
        // The two-word length is reserved and never acts, so only the one-word
        // length is compared.
        if (rx_byte == cfg.end_byte && frame_length == cfg.one_word_length) begin
          if (first_payload_byte == CMD_RESET_SAMPLE) result.action = ACT_RESET_SAMPLE;
          else if (first_payload_byte == CMD_SAMPLE_TIMER) result.action = ACT_SAMPLE_TIMER;
        end
        mode_next = MODE_IDLE;
      end
      MODE_COLLECT_3, MODE_COLLECT_4, MODE_COLLECT_8: begin
        if (payload_count == 4'd0) first_payload_byte_next = rx_byte;
        payload_count_next = payload_count + 4'd1;
        if ({4'd0, payload_count_next} >= frame_length) mode_next = MODE_END_CHECK;
      end
      default: begin
        mode_next       = MODE_IDLE;
        result.accepted = 1'b0;
      end
    endcase
  end

  a_reject_to_idle: assert property (@(posedge clk) disable iff (rst)
    (take && !result.accepted) |=> (mode == MODE_IDLE))
    else $error("parser did not return to idle after a rejected byte");

  a_reject_no_action: assert property (@(posedge clk) disable iff (rst)
    !result.accepted |-> (result.action == ACT_NONE))
    else $error("rejected byte carries an action");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_COLLECT_3 || mode == MODE_COLLECT_4 || mode == MODE_COLLECT_8)
      |-> ({4'd0, payload_count} < frame_length))
    else $error("payload count ran past the frame length");

endmodule

// File: rtl/length_framed_command_deframer_top.sv
// Top level of the length framed command deframer: config registers and result buffer.
`timescale 1ns / 1ps

// Takes one received serial byte per request and returns exactly one result (accepted,
// action) for each byte, one byte per clock cycle while in_stall is low. The parser
// state is updated by a single compare-and-increment step at the accepting edge; the
// result is written at that same edge into a two-entry buffer: the output entry, or
// the skid entry while the output entry is held. in_stall rises only while both
// buffer entries are full, so input keeps flowing while one result waits. Registers
// are written by index (0 start byte, 1 end byte, 2 one-word length, 3 two-words
// length); the user must write them only while idle; the block does not enforce it.

module length_framed_command_deframer_top import lfcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       accepted,
  output logic [1:0] action,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t    cfg;
  result_t result;
  result_t out_reg, skid_reg;
  logic    skid_valid;
  logic    take, out_taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte       <= RST_START_BYTE;
      cfg.end_byte         <= RST_END_BYTE;
      cfg.one_word_length  <= RST_ONE_WORD_LENGTH;
      cfg.two_words_length <= RST_TWO_WORDS_LENGTH;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_START_BYTE:       cfg.start_byte       <= cfg_data;
        REG_END_BYTE:         cfg.end_byte         <= cfg_data;
        REG_ONE_WORD_LENGTH:  cfg.one_word_length  <= cfg_data;
        REG_TWO_WORDS_LENGTH: cfg.two_words_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall  = skid_valid;
  assign take      = in_valid && !skid_valid;
  assign out_taken = out_valid && !out_stall;

  lfcd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .result  (result)
  );

  // The skid entry is filled only when a new result arrives while the output
  // entry is held, and drains into the output entry when that one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_taken) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (take) begin
        if (out_valid && out_stall) skid_valid <= 1'b1;
        else out_valid <= 1'b1;
      end else if (out_taken) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_taken) out_reg <= skid_reg;
    end else if (take) begin
      if (out_valid && out_stall) skid_reg <= result;
      else out_reg <= result;
    end
  end

  assign accepted = out_reg.accepted;
  assign action   = out_reg.action;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result while the output entry is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_stall) |=> (skid_valid && $stable(skid_reg)))
    else $error("buffered result lost while the output is stalled");

  a_action_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_reg.action == ACT_NONE || out_reg.action == ACT_RESET_SAMPLE
                   || out_reg.action == ACT_SAMPLE_TIMER))
    else $error("illegal action code on the output");

  a_result_follows_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted byte produced no result");

endmodule
